[sv/vtpg_pkg.sv]
// shared types, constants and helpers of the video test pattern generator
package vtpg_pkg;

	localparam int DIM_W     = 11;
	localparam int CHAN_W    = 8;
	localparam int BAND_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int DIM_MAX   = 2048;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
	localparam logic             PAT_BARS     = 1'b1;

	// floor(w / 7) == (w * 2341) >> 14 for every 11-bit w
	localparam logic [11:0] RECIP7       = 12'd2341;
	localparam int          RECIP7_SHIFT = 14;

	localparam logic [BAND_W-1:0] BAND_FIRST = 4'd1;
	localparam logic [BAND_W-1:0] BAND_WHITE = 4'd8;
	localparam logic [CHAN_W-1:0] CHAN_FULL  = 8'd255;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             pattern;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic pixel;
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
	} status_t;

	// zero acts like one, and the bound never passes the largest index
	function automatic logic [DIM_W-1:0] dim_bound(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > DIM_MAX - 1) begin
			r = DIM_W'(DIM_MAX - 1);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[sv/vtpg_div.sv]
// restoring divider, full scale by an interval, one quotient bit per cycle
module vtpg_div #(
	parameter int QW = 25,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quot_q;
	logic [DW:0]   trial;
	logic          ge;

	// dividend is a single one in its top bit
	assign trial = {rem_q, (cnt_q == '0)};
	assign ge    = trial >= {1'b0, divisor};
	assign done  = busy_q & (cnt_q == CW'(QW - 1));
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
			quot_q <= {quot_q[QW-2:0], ge};
			cnt_q  <= cnt_q + CW'(1);
			if (cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= CW'(QW - 1))
		else $error("divider step count past quotient width");
`endif

endmodule

[sv/vtpg_ctrl.sv]
// controller state machine: item acceptance, step division and pixel emission
module vtpg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              start_frame,
	output logic              in_stall,
	input  vtpg_pkg::status_t status,
	output vtpg_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   idle;
	logic   take;

	assign idle        = state_q == ST_IDLE;
	assign take        = idle & in_valid & status.out_free;
	assign in_stall    = !(idle & status.out_free);
	assign cmd.latch   = take & start_frame;
	assign cmd.pixel   = (take & !start_frame) | ((state_q == ST_EMIT) & status.out_free);
	assign cmd.restart = state_q == ST_EMIT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take & start_frame) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/vtpg_datapath.sv]
// datapath: position, color accumulators, step dividers and output register
module vtpg_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vtpg_pkg::cfg_t                cfg,
	input  vtpg_pkg::cmd_t                cmd,
	output vtpg_pkg::status_t             status,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [vtpg_pkg::CHAN_W-1:0]   chan_red,
	output logic [vtpg_pkg::CHAN_W-1:0]   chan_blue,
	output logic [vtpg_pkg::CHAN_W-1:0]   chan_green,
	output logic [vtpg_pkg::DIM_W-1:0]    pixel_column,
	output logic [vtpg_pkg::DIM_W-1:0]    pixel_row,
	output logic                          frame_last
);

	localparam int ACC_W  = FRAC_BITS + 10;
	localparam int STEP_W = FRAC_BITS + 9;
	localparam int SUM_W  = ACC_W + 1;
	localparam int DW     = vtpg_pkg::DIM_W;
	localparam int CW     = vtpg_pkg::CHAN_W;
	localparam int BW     = vtpg_pkg::BAND_W;
	localparam int TW     = DW + 3;

	localparam logic signed [ACC_W-1:0] FULL_ACC = {2'b01, {(FRAC_BITS + 8){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W - 1){1'b0}}};
	localparam logic [STEP_W-1:0]       FULL_BAR = {1'b1, {(FRAC_BITS + 8){1'b0}}};

	function automatic logic signed [ACC_W-1:0] sat_step(
		input logic signed [ACC_W-1:0] acc,
		input logic [STEP_W-1:0]       step,
		input logic                    sub
	);
		logic signed [SUM_W-1:0] a_ext;
		logic signed [SUM_W-1:0] s_ext;
		logic signed [SUM_W-1:0] sum;
		logic signed [ACC_W-1:0] r;
		a_ext = {acc[ACC_W-1], acc};
		s_ext = {2'b00, step};
		sum   = sub ? a_ext - s_ext : a_ext + s_ext;
		if (sum[SUM_W-1] != sum[SUM_W-2]) begin
			r = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end else begin
			r = sum[ACC_W-1:0];
		end
		return r;
	endfunction

	// negative reads 0, full scale or above reads 255
	function automatic logic [CW-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
		logic [CW-1:0] r;
		if (acc[ACC_W-1]) begin
			r = '0;
		end else if (acc[FRAC_BITS+8]) begin
			r = vtpg_pkg::CHAN_FULL;
		end else begin
			r = acc[FRAC_BITS+7:FRAC_BITS];
		end
		return r;
	endfunction

	// frame state
	logic [DW-1:0]           col_q, row_q;
	logic signed [ACC_W-1:0] red_q, blue_q, green_q;
	logic [STEP_W-1:0]       bar_q;
	logic [BW-1:0]           band_q;
	logic [DW-1:0]           col_int_q, row_int_q;

	// output register
	logic          out_valid_q;
	logic [CW-1:0] red_out_q, blue_out_q, green_out_q;
	logic [DW-1:0] col_out_q, row_out_q;
	logic          last_out_q;

	logic [STEP_W-1:0] col_step, row_step;
	logic              col_done, row_done;

	// state as seen by this pixel, frame start values on a restart
	logic [DW-1:0]           e_col, e_row;
	logic signed [ACC_W-1:0] e_red, e_blue, e_green;
	logic [STEP_W-1:0]       e_bar;
	logic [BW-1:0]           e_band;

	logic [DW-1:0]           n_col, n_row;
	logic signed [ACC_W-1:0] n_red, n_blue, n_green;
	logic [STEP_W-1:0]       n_bar;
	logic [BW-1:0]           n_band;

	logic [CW-1:0]   pix_r, pix_b, pix_g, bar_byte;
	logic            col_end, frm_end;
	logic [TW-1:0]   pos, ci, ci3, ci6, ci9;
	logic [STEP_W:0] bar_sum;
	logic signed [ACC_W-1:0] green_nx;

	logic [22:0]   prod7;
	logic [DW-1:0] ci_raw, ci_new, ri_raw, ri_new;

	assign e_col   = cmd.restart ? '0 : col_q;
	assign e_row   = cmd.restart ? '0 : row_q;
	assign e_red   = cmd.restart ? FULL_ACC : red_q;
	assign e_blue  = cmd.restart ? '0 : blue_q;
	assign e_green = cmd.restart ? '0 : green_q;
	assign e_bar   = cmd.restart ? '0 : bar_q;
	assign e_band  = cmd.restart ? vtpg_pkg::BAND_FIRST : band_q;

	// interval calculation at frame start
	assign prod7  = 23'(cfg.width) * 23'(vtpg_pkg::RECIP7);
	assign ci_raw = cfg.pattern ? DW'(prod7 >> vtpg_pkg::RECIP7_SHIFT) : (cfg.width >> 2);
	assign ci_new = (ci_raw == '0) ? DW'(1) : ci_raw;
	assign ri_raw = cfg.height >> 1;
	assign ri_new = (ri_raw == '0) ? DW'(1) : ri_raw;

	vtpg_div #(
		.QW(STEP_W),
		.DW(DW)
	) u_col_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.latch),
		.divisor(col_int_q),
		.done   (col_done),
		.quot   (col_step)
	);

	vtpg_div #(
		.QW(STEP_W),
		.DW(DW)
	) u_row_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.latch),
		.divisor(row_int_q),
		.done   (row_done),
		.quot   (row_step)
	);

	assign status.out_free = !out_valid_q | !out_stall;
	assign status.div_done = col_done & row_done;

	// pixel color
	assign bar_byte = e_bar[FRAC_BITS+8] ? vtpg_pkg::CHAN_FULL : e_bar[FRAC_BITS+7:FRAC_BITS];

	always_comb begin
		if (cfg.pattern) begin
			if (e_band >= vtpg_pkg::BAND_WHITE) begin
				pix_r = vtpg_pkg::CHAN_FULL;
				pix_b = vtpg_pkg::CHAN_FULL;
				pix_g = vtpg_pkg::CHAN_FULL;
			end else begin
				pix_r = e_band[0] ? bar_byte : '0;
				pix_b = e_band[1] ? bar_byte : '0;
				pix_g = e_band[2] ? bar_byte : '0;
			end
		end else begin
			pix_r = to_byte(e_red);
			pix_b = to_byte(e_blue);
			pix_g = to_byte(e_green);
		end
	end

	assign col_end = ({1'b0, e_row} + 12'd1) >= {1'b0, vtpg_pkg::dim_bound(cfg.height)};
	assign frm_end = col_end
		&& (({1'b0, e_col} + 12'd1) >= {1'b0, vtpg_pkg::dim_bound(cfg.width)});

	assign green_nx = sat_step(e_green, row_step, !(e_row < row_int_q));

	// gradient breakpoints in quarter-column units
	assign pos     = {1'b0, e_col, 2'b00};
	assign ci      = TW'(col_int_q);
	assign ci3     = (ci << 1) + ci;
	assign ci6     = ci3 << 1;
	assign ci9     = (ci << 3) + ci;
	assign bar_sum = {1'b0, e_bar} + {1'b0, col_step};

	always_comb begin
		n_col   = e_col;
		n_row   = e_row;
		n_red   = e_red;
		n_blue  = e_blue;
		n_green = green_nx;
		n_bar   = e_bar;
		n_band  = e_band;
		if (frm_end) begin
			n_col   = '0;
			n_row   = '0;
			n_red   = FULL_ACC;
			n_blue  = '0;
			n_green = '0;
			n_bar   = '0;
			n_band  = vtpg_pkg::BAND_FIRST;
		end else if (col_end) begin
			if (pos < ci3) begin
				n_blue = '0;
				n_red  = sat_step(e_red, col_step, 1'b1);
			end else if (pos < ci6) begin
				n_blue = sat_step(e_blue, col_step, 1'b0);
				n_red  = sat_step(e_red, col_step, 1'b0);
			end else if (pos < ci9) begin
				n_blue = sat_step(e_blue, col_step, 1'b1);
				n_red  = sat_step(e_red, col_step, 1'b1);
			end else begin
				n_blue = sat_step(e_blue, col_step, 1'b0);
				n_red  = '0;
			end
			if (bar_sum >= {1'b0, FULL_BAR}) begin
				n_bar = '0;
				if (e_band < vtpg_pkg::BAND_WHITE) begin
					n_band = e_band + BW'(1);
				end
			end else begin
				n_bar = bar_sum[STEP_W-1:0];
			end
			n_green = '0;
			n_row   = '0;
			n_col   = e_col + DW'(1);
		end else begin
			n_row = e_row + DW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			red_q     <= FULL_ACC;
			blue_q    <= '0;
			green_q   <= '0;
			bar_q     <= '0;
			band_q    <= vtpg_pkg::BAND_FIRST;
			col_int_q <= '0;
			row_int_q <= '0;
		end else begin
			if (cmd.latch) begin
				col_int_q <= ci_new;
				row_int_q <= ri_new;
			end
			if (cmd.pixel) begin
				col_q   <= n_col;
				row_q   <= n_row;
				red_q   <= n_red;
				blue_q  <= n_blue;
				green_q <= n_green;
				bar_q   <= n_bar;
				band_q  <= n_band;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pixel) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pixel) begin
			red_out_q   <= pix_r;
			blue_out_q  <= pix_b;
			green_out_q <= pix_g;
			col_out_q   <= e_col;
			row_out_q   <= e_row;
			last_out_q  <= frm_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign chan_red     = red_out_q;
	assign chan_blue    = blue_out_q;
	assign chan_green   = green_out_q;
	assign pixel_column = col_out_q;
	assign pixel_row    = row_out_q;
	assign frame_last   = last_out_q;

`ifndef SYNTHESIS
	a_pixel_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pixel |=> out_valid_q)
		else $error("computed pixel did not reach the output register");

	a_bar_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		bar_q < FULL_BAR)
		else $error("bar ramp reached full scale without wrapping");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		band_q >= vtpg_pkg::BAND_FIRST && band_q <= vtpg_pkg::BAND_WHITE)
		else $error("band number out of range");
`endif

endmodule

[sv/video_test_pattern_generator.sv]
// a pixel item shows in the output register in the cycle after it is accepted
// throughput: one pixel item per cycle while the output is not stalled and no start_frame item is in progress
// a start_frame item waits on the bit-serial step dividers, one quotient bit per cycle
// reset: position at column 0 row 0, steps zero, width 640, height 480, color bars
module video_test_pattern_generator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           start_frame,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [vtpg_pkg::CHAN_W-1:0]    chan_red,
	output logic [vtpg_pkg::CHAN_W-1:0]    chan_blue,
	output logic [vtpg_pkg::CHAN_W-1:0]    chan_green,
	output logic [vtpg_pkg::DIM_W-1:0]     pixel_column,
	output logic [vtpg_pkg::DIM_W-1:0]     pixel_row,
	output logic                           frame_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtpg_pkg::DIM_W-1:0]     cfg_data
);

	vtpg_pkg::cfg_t    cfg_q;
	vtpg_pkg::cmd_t    cmd;
	vtpg_pkg::status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= vtpg_pkg::WIDTH_RESET;
			cfg_q.height  <= vtpg_pkg::HEIGHT_RESET;
			cfg_q.pattern <= vtpg_pkg::PAT_BARS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vtpg_pkg::REG_WIDTH:   cfg_q.width   <= cfg_data;
				vtpg_pkg::REG_HEIGHT:  cfg_q.height  <= cfg_data;
				vtpg_pkg::REG_PATTERN: cfg_q.pattern <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vtpg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.start_frame(start_frame),
		.in_stall   (in_stall),
		.status     (status),
		.cmd        (cmd)
	);

	vtpg_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.status      (status),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.chan_red    (chan_red),
		.chan_blue   (chan_blue),
		.chan_green  (chan_green),
		.pixel_column(pixel_column),
		.pixel_row   (pixel_row),
		.frame_last  (frame_last)
	);

endmodule
